// ===== hdl/alignment_flag_statistics_assert.svh =====
// Assertion macros for the alignment flag statistics block.
// Used by the top level; needs clk and rst_n in the scope of the caller.
`ifndef ALIGNMENT_FLAG_STATISTICS_ASSERT_SVH
`define ALIGNMENT_FLAG_STATISTICS_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AFS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("afs: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define AFS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("afs: next-cycle check failed");

`endif

// ===== hdl/afs_pkg.sv =====
// Shared types and constants for the alignment flag statistics block.
// No dependencies; imported by every module of the block.
`default_nettype none

package afs_pkg;

    localparam int COUNTER_BITS_DEF = 48;
    localparam int OUT_W            = 48;
    localparam int NUM_STATS        = 16;
    localparam int STAT_IDX_W       = 4;
    localparam int CMD_W            = 2;
    localparam int FLAG_W           = 12;
    localparam int REF_W            = 32;
    localparam int MAPQ_W           = 8;

    localparam logic [MAPQ_W-1:0] MAPQ_LIMIT = 8'd5;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_COUNT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // SAM flag bit positions.
    localparam int FB_PAIRED     = 0;
    localparam int FB_PROPER     = 1;
    localparam int FB_UNMAPPED   = 2;
    localparam int FB_MATE_UNMAP = 3;
    localparam int FB_READ1      = 6;
    localparam int FB_READ2      = 7;
    localparam int FB_SECONDARY  = 8;
    localparam int FB_QCFAIL     = 9;
    localparam int FB_DUP        = 10;
    localparam int FB_SUPPL      = 11;

    // Statistic indexes.
    localparam int ST_TOTAL       = 0;
    localparam int ST_PRIMARY     = 1;
    localparam int ST_SECONDARY   = 2;
    localparam int ST_SUPPL       = 3;
    localparam int ST_DUP         = 4;
    localparam int ST_PRIM_DUP    = 5;
    localparam int ST_MAPPED      = 6;
    localparam int ST_PRIM_MAPPED = 7;
    localparam int ST_PAIRED      = 8;
    localparam int ST_READ1       = 9;
    localparam int ST_READ2       = 10;
    localparam int ST_PROPER      = 11;
    localparam int ST_BOTH_MAPPED = 12;
    localparam int ST_SINGLETON   = 13;
    localparam int ST_DIFF_REF    = 14;
    localparam int ST_DIFF_REF_Q5 = 15;

    // Which statistics one record bumps, and on which side (1 = QC failed).
    typedef struct packed {
        logic [NUM_STATS-1:0] hit;
        logic                 side;
    } afs_bump_t;

endpackage

`default_nettype wire

// ===== hdl/afs_decode.sv =====
// Flag decoder: turns one record into the set of statistics it counts in.
// Depends on afs_pkg.
`default_nettype none

module afs_decode (
    input  wire logic [afs_pkg::FLAG_W-1:0] flag_word,
    input  wire logic signed [afs_pkg::REF_W-1:0] ref_id,
    input  wire logic signed [afs_pkg::REF_W-1:0] mate_ref_id,
    input  wire logic [afs_pkg::MAPQ_W-1:0] map_quality,
    output afs_pkg::afs_bump_t              bump
);
    import afs_pkg::*;

    logic secondary;
    logic suppl;
    logic primary;
    logic paired;
    logic mapped;
    logic mate_aligned;
    logic dup;
    logic pp;
    logic both;
    logic diff_ref;

    always_comb
    begin
        secondary    = flag_word[FB_SECONDARY];
        suppl        = !secondary && flag_word[FB_SUPPL];
        primary      = !secondary && !suppl;
        paired       = flag_word[FB_PAIRED];
        mapped       = !flag_word[FB_UNMAPPED];
        mate_aligned = !flag_word[FB_MATE_UNMAP];
        dup          = flag_word[FB_DUP];
        pp           = primary && paired;
        both         = pp && mapped && mate_aligned;
        diff_ref     = both && (ref_id != mate_ref_id);

        bump.side                 = flag_word[FB_QCFAIL];
        bump.hit                  = '0;
        bump.hit[ST_TOTAL]        = 1'b1;
        bump.hit[ST_PRIMARY]      = primary;
        bump.hit[ST_SECONDARY]    = secondary;
        bump.hit[ST_SUPPL]        = suppl;
        bump.hit[ST_DUP]          = dup;
        bump.hit[ST_PRIM_DUP]     = primary && dup;
        bump.hit[ST_MAPPED]       = mapped;
        bump.hit[ST_PRIM_MAPPED]  = primary && mapped;
        bump.hit[ST_PAIRED]       = pp;
        bump.hit[ST_READ1]        = pp && flag_word[FB_READ1];
        bump.hit[ST_READ2]        = pp && flag_word[FB_READ2];
        bump.hit[ST_PROPER]       = pp && flag_word[FB_PROPER] && mapped;
        bump.hit[ST_BOTH_MAPPED]  = both;
        bump.hit[ST_SINGLETON]    = pp && mapped && !mate_aligned;
        bump.hit[ST_DIFF_REF]     = diff_ref;
        bump.hit[ST_DIFF_REF_Q5]  = diff_ref && (map_quality >= MAPQ_LIMIT);
    end

endmodule

`default_nettype wire

// ===== hdl/afs_counter_bank.sv =====
// Bank of saturating QC-passed and QC-failed counters, one pair per statistic.
// Depends on afs_pkg.
`default_nettype none

module afs_counter_bank #(
    parameter int COUNTER_BITS = afs_pkg::COUNTER_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           count_en,
    input  wire logic                           clear_en,
    input  wire afs_pkg::afs_bump_t             bump,
    input  wire logic [afs_pkg::STAT_IDX_W-1:0] rd_index,
    output logic [afs_pkg::OUT_W-1:0]           rd_passed,
    output logic [afs_pkg::OUT_W-1:0]           rd_failed
);
    import afs_pkg::*;

    localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

    logic [COUNTER_BITS-1:0] pass_reg  [NUM_STATS];
    logic [COUNTER_BITS-1:0] fail_reg  [NUM_STATS];
    logic [COUNTER_BITS-1:0] pass_next [NUM_STATS];
    logic [COUNTER_BITS-1:0] fail_next [NUM_STATS];

    always_comb
    begin
        for (int i = 0; i < NUM_STATS; i++)
        begin
            pass_next[i] = pass_reg[i];
            fail_next[i] = fail_reg[i];
            if (clear_en)
            begin
                pass_next[i] = '0;
                fail_next[i] = '0;
            end
            else if (count_en && bump.hit[i])
            begin
                // A full counter holds at its maximum.
                if (!bump.side && (pass_reg[i] != CNT_MAX))
                begin
                    pass_next[i] = pass_reg[i] + COUNTER_BITS'(1);
                end
                if (bump.side && (fail_reg[i] != CNT_MAX))
                begin
                    fail_next[i] = fail_reg[i] + COUNTER_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STATS; i++)
            begin
                pass_reg[i] <= '0;
                fail_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_STATS; i++)
            begin
                pass_reg[i] <= pass_next[i];
                fail_reg[i] <= fail_next[i];
            end
        end
    end

    assign rd_passed = OUT_W'(pass_reg[rd_index]);
    assign rd_failed = OUT_W'(fail_reg[rd_index]);

endmodule

`default_nettype wire

// ===== hdl/alignment_flag_statistics.sv =====
// Read path: a read beat is held in the input register, then its result is
// presented from the result register (input register, then result register).
// Throughput: one beat per cycle; the input stalls only when a read beat
// waits on a result register that is full and stalled.
// Reset: asynchronous, active low; all counters and valids clear at once.
// Top level of the alignment flag statistics block; uses afs_pkg, afs_decode
// and afs_counter_bank.
`default_nettype none

module alignment_flag_statistics #(
    parameter int COUNTER_BITS = afs_pkg::COUNTER_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           item_valid,
    output logic                                item_stall,
    input  wire logic [afs_pkg::CMD_W-1:0]      cmd,
    input  wire logic [afs_pkg::FLAG_W-1:0]     flag_word,
    input  wire logic signed [afs_pkg::REF_W-1:0] ref_id,
    input  wire logic signed [afs_pkg::REF_W-1:0] mate_ref_id,
    input  wire logic [afs_pkg::MAPQ_W-1:0]     map_quality,
    input  wire logic [afs_pkg::STAT_IDX_W-1:0] stat_index,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output logic [afs_pkg::OUT_W-1:0]           passed_count,
    output logic [afs_pkg::OUT_W-1:0]           failed_count
);
    import afs_pkg::*;

    logic                          a_valid_reg;
    logic                          a_valid_next;
    logic [CMD_W-1:0]              a_cmd_reg;
    logic [FLAG_W-1:0]             a_flag_reg;
    logic signed [REF_W-1:0]       a_ref_reg;
    logic signed [REF_W-1:0]       a_mref_reg;
    logic [MAPQ_W-1:0]             a_mapq_reg;
    logic [STAT_IDX_W-1:0]         a_idx_reg;
    logic                          a_move;
    logic                          item_accept;

    logic                          res_valid_reg;
    logic                          res_valid_next;
    logic [OUT_W-1:0]              res_pass_reg;
    logic [OUT_W-1:0]              res_fail_reg;

    afs_bump_t                     bump;
    logic [OUT_W-1:0]              rd_passed;
    logic [OUT_W-1:0]              rd_failed;
    logic                          read_move;

    // Only a read beat can be held, and only behind a full, stalled result.
    assign item_stall  = a_valid_reg && (a_cmd_reg == CMD_READ)
                         && res_valid_reg && result_stall;
    assign a_move      = a_valid_reg && !item_stall;
    assign item_accept = item_valid && !item_stall;
    assign read_move   = a_move && (a_cmd_reg == CMD_READ);

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (item_accept)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_move)
        begin
            a_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (read_move)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !result_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            a_cmd_reg  <= cmd;
            a_flag_reg <= flag_word;
            a_ref_reg  <= ref_id;
            a_mref_reg <= mate_ref_id;
            a_mapq_reg <= map_quality;
            a_idx_reg  <= stat_index;
        end
        if (read_move)
        begin
            res_pass_reg <= rd_passed;
            res_fail_reg <= rd_failed;
        end
    end

    afs_decode u_decode (
        .flag_word   (a_flag_reg),
        .ref_id      (a_ref_reg),
        .mate_ref_id (a_mref_reg),
        .map_quality (a_mapq_reg),
        .bump        (bump)
    );

    afs_counter_bank #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_bank (
        .clk       (clk),
        .rst_n     (rst_n),
        .count_en  (a_move && (a_cmd_reg == CMD_COUNT)),
        .clear_en  (a_move && (a_cmd_reg == CMD_CLEAR)),
        .bump      (bump),
        .rd_index  (a_idx_reg),
        .rd_passed (rd_passed),
        .rd_failed (rd_failed)
    );

    assign result_valid = res_valid_reg;
    assign passed_count = res_pass_reg;
    assign failed_count = res_fail_reg;

`include "alignment_flag_statistics_assert.svh"

    `AFS_ASSERT_NOW(a_stall_needs_beat, item_stall, a_valid_reg)
    `AFS_ASSERT_NOW(a_count_never_stalls, a_valid_reg && (a_cmd_reg == CMD_COUNT), !item_stall)
    `AFS_ASSERT_NEXT(a_read_gives_result, read_move, res_valid_reg)

endmodule

`default_nettype wire
